// ----- design/pbb64rle_pkg.sv -----
// Shared constants, types and character mapping for the pitch bend base64 run-length decoder.
`default_nettype none

package pbb64rle_pkg;

  localparam int CharWidth   = 8;
  localparam int SextetWidth = 6;
  localparam int SampleWidth = 12;
  localparam int RepeatWidth = 16;

  typedef logic [CharWidth-1:0]   char_t;
  typedef logic [SextetWidth-1:0] sextet_t;
  typedef logic [SampleWidth-1:0] sample_t;
  typedef logic [RepeatWidth-1:0] repeat_t;

  localparam char_t HASH_CHAR  = 8'h23;  // '#'
  localparam char_t DIGIT_LO   = 8'h30;  // '0'
  localparam char_t DIGIT_HI   = 8'h39;  // '9'
  localparam char_t UPPER_LO   = 8'h41;  // 'A'
  localparam char_t UPPER_HI   = 8'h5a;  // 'Z'
  localparam char_t LOWER_LO   = 8'h61;  // 'a'
  localparam char_t LOWER_HI   = 8'h7a;  // 'z'
  localparam char_t PLUS_CHAR  = 8'h2b;  // '+'
  localparam char_t SLASH_CHAR = 8'h2f;  // '/'

  localparam sextet_t LOWER_BASE = 6'd26;
  localparam sextet_t DIGIT_BASE = 6'd52;
  localparam sextet_t PLUS_VAL   = 6'd62;
  localparam sextet_t SLASH_VAL  = 6'd63;

  function automatic logic is_digit(input char_t c);
    is_digit = (c >= DIGIT_LO) && (c <= DIGIT_HI);
  endfunction

  // Map one character to its base64 value; anything outside the alphabet gives zero.
  function automatic sextet_t b64_value(input char_t c);
    char_t   off;
    sextet_t v;
    off = '0;
    v   = '0;
    if (is_digit(c)) begin
      off = c - DIGIT_LO;
      v   = DIGIT_BASE + off[SextetWidth-1:0];
    end else if ((c >= UPPER_LO) && (c <= UPPER_HI)) begin
      off = c - UPPER_LO;
      v   = off[SextetWidth-1:0];
    end else if ((c >= LOWER_LO) && (c <= LOWER_HI)) begin
      off = c - LOWER_LO;
      v   = LOWER_BASE + off[SextetWidth-1:0];
    end else if (c == PLUS_CHAR) begin
      v = PLUS_VAL;
    end else if (c == SLASH_CHAR) begin
      v = SLASH_VAL;
    end
    b64_value = v;
  endfunction

endpackage

`default_nettype wire

// ----- design/pitch_bend_base64_rle_decoder_top.sv -----
// Pitch bend base64 run-length decoder: character stream in, sample/repeat requests out.
//
// Usage: one character arrives per input request (in_char_code, in_last marks the
// final character of a string). Each completed base64 pair gives one result with
// out_repeat_res = 1; a '#'-delimited run gives one result carrying the last sample
// and its repeat count. Counts are clipped to the remaining capacity (max_samples);
// a count clipped to zero gives no result. Capacity is set through the cfg_ write
// channel, which is always ready; write it only while no request is in flight.
// A result appears on the out_ channel in the cycle after the character
// that causes it is accepted. Throughput: one character per cycle while
// in_stall is low; all decoding is one pass of logic from the accepted
// character and the small string state into the result register.
// Reset (synchronous, rst_n low) clears the string state, empties the result
// register and sets max_samples to 65535. After a character with in_last set,
// the string state returns to its reset value.
// When out_stall holds a pending result, in_stall rises in the same cycle and
// the result stays put; as soon as the result register is free or being
// drained, the next character is taken.
`default_nettype none

module pitch_bend_base64_rle_decoder_top #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire  pbb64rle_pkg::char_t in_char_code,
  input  wire                      in_last,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic signed [11:0]       out_sample,
  output pbb64rle_pkg::repeat_t    out_repeat_res,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  pbb64rle_pkg::repeat_t cfg_max_samples
);

  import pbb64rle_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > RepeatWidth) ? COUNT_WIDTH : RepeatWidth;
  localparam int MUL_W = COUNT_WIDTH + 4;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CMP_W-1:0]       cmp_t;

  // Configuration and string state
  repeat_t max_samples_r;
  logic    pair_phase_r,    pair_phase_nxt;
  sextet_t high_sextet_r,   high_sextet_nxt;
  sample_t last_sample_r,   last_sample_nxt;
  logic    in_run_r,        in_run_nxt;
  logic    digits_open_r,   digits_open_nxt;
  count_t  run_count_r,     run_count_nxt;
  repeat_t emitted_count_r, emitted_count_nxt;

  // Result register
  logic    out_valid_r;
  sample_t out_sample_r;
  repeat_t out_repeat_r;

  logic    in_accept;
  logic    is_hash;
  logic    is_dig;
  sextet_t sextet;
  logic [3:0] digit_off;
  logic [MUL_W-1:0] rc_mul;
  count_t  rc_upd;
  logic    emit_req;
  cmp_t    emit_cnt;
  repeat_t room;
  cmp_t    clipped;
  repeat_t emit_val;
  logic    emit_ok;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign is_hash   = (in_char_code == HASH_CHAR);
  assign is_dig    = is_digit(in_char_code);
  assign sextet    = b64_value(in_char_code);
  assign digit_off = 4'(in_char_code - DIGIT_LO);

  // run_count * 10 + digit, saturating at the counter's full scale
  assign rc_mul = MUL_W'({run_count_r, 3'b000}) + MUL_W'({run_count_r, 1'b0})
                + MUL_W'(digit_off);
  assign rc_upd = (rc_mul[MUL_W-1:COUNT_WIDTH] != '0) ? '1 : rc_mul[COUNT_WIDTH-1:0];

  always_comb begin
    pair_phase_nxt  = pair_phase_r;
    high_sextet_nxt = high_sextet_r;
    last_sample_nxt = last_sample_r;
    in_run_nxt      = in_run_r;
    digits_open_nxt = digits_open_r;
    run_count_nxt   = run_count_r;
    emit_req        = 1'b0;
    emit_cnt        = CMP_W'(1);
    if (in_run_r) begin
      if (is_hash) begin
        emit_req        = 1'b1;
        emit_cnt        = CMP_W'(run_count_r);
        in_run_nxt      = 1'b0;
        digits_open_nxt = 1'b0;
        run_count_nxt   = '0;
      end else begin
        if (digits_open_r && is_dig) begin
          run_count_nxt = rc_upd;
        end else begin
          digits_open_nxt = 1'b0;
        end
        if (in_last) begin
          emit_req = 1'b1;
          emit_cnt = CMP_W'(run_count_nxt);
        end
      end
    end else if (!pair_phase_r) begin
      if (is_hash) begin
        in_run_nxt      = 1'b1;
        digits_open_nxt = 1'b1;
        run_count_nxt   = '0;
      end else begin
        high_sextet_nxt = sextet;
        pair_phase_nxt  = 1'b1;
        if (in_last) begin
          // lone trailing character pairs with zero
          last_sample_nxt = {sextet, 6'b000000};
          emit_req        = 1'b1;
        end
      end
    end else begin
      last_sample_nxt = {high_sextet_r, sextet};
      pair_phase_nxt  = 1'b0;
      emit_req        = 1'b1;
    end
  end

  // Clip the count to the remaining capacity
  assign room     = (emitted_count_r < max_samples_r) ? (max_samples_r - emitted_count_r) : '0;
  assign clipped  = (emit_cnt > CMP_W'(room)) ? CMP_W'(room) : emit_cnt;
  assign emit_val = clipped[RepeatWidth-1:0];
  assign emit_ok  = emit_req && (emit_val != '0);
  assign emitted_count_nxt = emit_ok ? (emitted_count_r + emit_val) : emitted_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_samples_r <= '1;
    end else if (cfg_valid && cfg_ready) begin
      max_samples_r <= cfg_max_samples;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_phase_r    <= 1'b0;
      high_sextet_r   <= '0;
      last_sample_r   <= '0;
      in_run_r        <= 1'b0;
      digits_open_r   <= 1'b0;
      run_count_r     <= '0;
      emitted_count_r <= '0;
    end else if (in_accept) begin
      if (in_last) begin
        // end of string: restart
        pair_phase_r    <= 1'b0;
        high_sextet_r   <= '0;
        last_sample_r   <= '0;
        in_run_r        <= 1'b0;
        digits_open_r   <= 1'b0;
        run_count_r     <= '0;
        emitted_count_r <= '0;
      end else begin
        pair_phase_r    <= pair_phase_nxt;
        high_sextet_r   <= high_sextet_nxt;
        last_sample_r   <= last_sample_nxt;
        in_run_r        <= in_run_nxt;
        digits_open_r   <= digits_open_nxt;
        run_count_r     <= run_count_nxt;
        emitted_count_r <= emitted_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= emit_ok;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit_ok) begin
      out_sample_r <= last_sample_nxt;
      out_repeat_r <= emit_val;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample     = $signed(out_sample_r);
  assign out_repeat_res = out_repeat_r;

  // A delivered result never stands for zero copies
  a_repeat_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_repeat_res != '0))
    else $error("result with zero repeat count");

  // A run is only opened at a pair boundary
  a_run_at_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    in_run_r |-> !pair_phase_r)
    else $error("run open while a high sextet is held");

  // Digits are collected only inside a run
  a_digits_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    digits_open_r |-> in_run_r)
    else $error("digit collection outside a run");

  // The final character of a string restarts the string state
  a_restart_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_last) |=>
      (!in_run_r && !pair_phase_r && (emitted_count_r == '0) && (last_sample_r == '0)))
    else $error("string state not cleared after final character");

endmodule

`default_nettype wire

// ----- tb/sv/pitch_bend_base64_rle_decoder_top_tb.sv -----
// Self-checking testbench for the pitch bend base64 run-length decoder.
`timescale 1ns / 100ps

module pitch_bend_base64_rle_decoder_top_tb;
  import pbb64rle_pkg::*;

  localparam int CountWidth = 16;
  localparam longint unsigned CountMax = (64'd1 << CountWidth) - 1;
  localparam int DrainCycles = 4;
  localparam int CycleLimit = 400000;
  localparam int NumDirRows = 33;
  localparam int NumPhases = 8;
  localparam int HoldCycles = 60;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_RESULT,
    ROW_NONE,
    ROW_CAP
  } row_kind_t;

  typedef struct packed {
    char_t     chr;
    logic      fin;
    row_kind_t kind;
    sample_t   smp;
    repeat_t   cnt;
  } dir_row_t;

  typedef struct packed {
    sample_t smp;
    repeat_t cnt;
  } run_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  char_t in_char_code = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [11:0] out_sample;
  repeat_t out_repeat_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  repeat_t cfg_max_samples = '0;

  // sideband that travels with each request on the input channel
  row_kind_t item_kind = ROW_PREDICT;
  sample_t item_smp = '0;
  repeat_t item_cnt = '0;

  // decoder state mirror
  logic half_held;
  sextet_t hi_sextet;
  sample_t prev_sample;
  logic run_open;
  logic digits_live;
  longint unsigned run_total;
  int unsigned emitted;
  int unsigned capacity;

  run_t pending_runs[$];
  int mismatches = 0;
  int results_seen = 0;
  int chars_sent = 0;
  int strings_sent = 0;
  int cap_writes = 0;
  int cycle_cnt = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  logic hold_on = 1'b0;

  dir_row_t dir_rows [NumDirRows] = '{
    '{"/",       1'b0, ROW_NONE,    12'h000, 16'd0},
    '{"/",       1'b0, ROW_RESULT,  12'hFFF, 16'd1},
    '{"g",       1'b0, ROW_NONE,    12'h000, 16'd0},
    '{"A",       1'b0, ROW_RESULT,  12'h800, 16'd1},
    '{"f",       1'b0, ROW_NONE,    12'h000, 16'd0},
    '{"/",       1'b0, ROW_RESULT,  12'h7FF, 16'd1},
    '{8'hFF,     1'b0, ROW_NONE,    12'h000, 16'd0},
    '{8'h00,     1'b0, ROW_RESULT,  12'h000, 16'd1},
    '{"Z",       1'b0, ROW_NONE,    12'h000, 16'd0},
    '{HASH_CHAR, 1'b0, ROW_RESULT,  12'h640, 16'd1},
    '{"+",       1'b0, ROW_PREDICT, 12'h000, 16'd0},
    '{"9",       1'b0, ROW_PREDICT, 12'h000, 16'd0},
    '{HASH_CHAR, 1'b0, ROW_NONE,    12'h000, 16'd0},
    '{"7",       1'b0, ROW_PREDICT, 12'h000, 16'd0},
    '{"0",       1'b0, ROW_PREDICT, 12'h000, 16'd0},
    '{"0",       1'b0, ROW_PREDICT, 12'h000, 16'd0},
    '{"0",       1'b0, ROW_PREDICT, 12'h000, 16'd0},
    '{"0",       1'b0, ROW_PREDICT, 12'h000, 16'd0},
    '{"x",       1'b0, ROW_PREDICT, 12'h000, 16'd0},
    '{"3",       1'b0, ROW_NONE,    12'h000, 16'd0},
    '{HASH_CHAR, 1'b0, ROW_PREDICT, 12'h000, 16'd0},
    '{"B",       1'b1, ROW_NONE,    12'h000, 16'd0},
    '{HASH_CHAR, 1'b0, ROW_NONE,    12'h000, 16'd0},
    '{"5",       1'b1, ROW_RESULT,  12'h000, 16'd5},
    '{"B",       1'b1, ROW_RESULT,  12'h040, 16'd1},
    '{8'h00,     1'b0, ROW_CAP,     12'h000, 16'd0},
    '{"A",       1'b1, ROW_NONE,    12'h000, 16'd0},
    '{8'h00,     1'b0, ROW_CAP,     12'h000, 16'd3},
    '{HASH_CHAR, 1'b0, ROW_NONE,    12'h000, 16'd0},
    '{HASH_CHAR, 1'b0, ROW_NONE,    12'h000, 16'd0},
    '{HASH_CHAR, 1'b0, ROW_NONE,    12'h000, 16'd0},
    '{"4",       1'b0, ROW_PREDICT, 12'h000, 16'd0},
    '{HASH_CHAR, 1'b1, ROW_RESULT,  12'h000, 16'd3}
  };

  pitch_bend_base64_rle_decoder_top #(
    .COUNT_WIDTH(CountWidth)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample     (out_sample),
    .out_repeat_res (out_repeat_res),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_max_samples(cfg_max_samples)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("Timeout after %0d cycles with %0d results pending", cycle_cnt,
             pending_runs.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic sextet_t sextet_of(input char_t c);
    if (c >= UPPER_LO && c <= UPPER_HI) return sextet_t'(c - UPPER_LO);
    if (c >= LOWER_LO && c <= LOWER_HI) return sextet_t'(c - LOWER_LO + 8'd26);
    if (c >= DIGIT_LO && c <= DIGIT_HI) return sextet_t'(c - DIGIT_LO + 8'd52);
    if (c == PLUS_CHAR) return 6'd62;
    if (c == SLASH_CHAR) return 6'd63;
    return 6'd0;
  endfunction

  function automatic void clear_string();
    half_held = 1'b0;
    hi_sextet = '0;
    prev_sample = '0;
    run_open = 1'b0;
    digits_live = 1'b0;
    run_total = 0;
    emitted = 0;
  endfunction

  // Clip to the room left in this string; a zero count gives nothing.
  function automatic void emit_run(input longint unsigned count, output logic hit,
                                   output run_t run);
    longint unsigned room;
    room = (emitted < capacity) ? longint'(capacity - emitted) : 0;
    hit = 1'b0;
    run = '0;
    if (count > room) count = room;
    if (count != 0) begin
      emitted = (emitted + int'(count)) & 32'hFFFF;
      hit = 1'b1;
      run.smp = prev_sample;
      run.cnt = repeat_t'(count);
    end
  endfunction

  function automatic void decode_char(input char_t c, input logic fin, output logic hit,
                                      output run_t run);
    longint unsigned grown;
    hit = 1'b0;
    run = '0;
    if (run_open) begin
      if (c == HASH_CHAR) begin
        emit_run(run_total, hit, run);
        run_open = 1'b0;
        digits_live = 1'b0;
        run_total = 0;
      end else begin
        if (digits_live && c >= DIGIT_LO && c <= DIGIT_HI) begin
          grown = run_total * 10 + longint'(c - DIGIT_LO);
          run_total = (grown > CountMax) ? CountMax : grown;
        end else begin
          digits_live = 1'b0;
        end
        if (fin) emit_run(run_total, hit, run);
      end
    end else if (!half_held) begin
      if (c == HASH_CHAR) begin
        run_open = 1'b1;
        digits_live = 1'b1;
        run_total = 0;
      end else begin
        hi_sextet = sextet_of(c);
        half_held = 1'b1;
        if (fin) begin
          prev_sample = {hi_sextet, 6'd0};
          emit_run(1, hit, run);
        end
      end
    end else begin
      prev_sample = {hi_sextet, sextet_of(c)};
      half_held = 1'b0;
      emit_run(1, hit, run);
    end
    if (fin) clear_string();
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s at %0t ns: got %0d, want %0d", what, $time, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    run_t want;
    run_t fresh;
    logic hit;
    if (!rst_n) begin
      capacity = 16'hFFFF;
      clear_string();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_runs.size() == 0) begin
          report_mismatch("result with nothing pending, sample", int'(out_sample), 0);
        end else begin
          want = pending_runs.pop_front();
          if (out_sample !== want.smp)
            report_mismatch("sample", int'(out_sample), int'($signed(want.smp)));
          if (out_repeat_res !== want.cnt)
            report_mismatch("repeat", int'(out_repeat_res), int'(want.cnt));
        end
      end
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_max_samples;
        cap_writes++;
      end
      if (in_valid && !in_stall) begin
        decode_char(in_char_code, in_last, hit, fresh);
        case (item_kind)
          ROW_RESULT: pending_runs.push_back('{smp: item_smp, cnt: item_cnt});
          ROW_NONE: ;
          default: if (hit) pending_runs.push_back(fresh);
        endcase
      end
    end
  end

  // Long hold-off: count the stretch in cycles once the stimulus asks for it.
  initial begin
    int seen;
    seen = 0;
    forever begin
      wait (hold_req != seen);
      seen = hold_req;
      @(posedge clk);
      hold_on = 1'b1;
      repeat (HoldCycles) @(posedge clk);
      hold_on = 1'b0;
    end
  end

  // Receiver: hold off while the long stretch runs, otherwise stall at random.
  always @(negedge clk) begin
    if (hold_on) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_char(input char_t c, input logic fin, input row_kind_t kind,
                           input sample_t smp, input repeat_t cnt);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk) in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_char_code <= c;
    in_last <= fin;
    item_kind <= kind;
    item_smp <= smp;
    item_cnt <= cnt;
    do @(posedge clk); while (in_stall);
    chars_sent++;
    if (fin) strings_sent++;
  endtask

  // Drop valid and hold until every pending result is out, plus the latency.
  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic set_capacity(input repeat_t cap);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_max_samples <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  function automatic char_t b64_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return char_t'(UPPER_LO + $urandom_range(0, 25));
      3, 4, 5: return char_t'(LOWER_LO + $urandom_range(0, 25));
      6, 7:    return char_t'(DIGIT_LO + $urandom_range(0, 9));
      8:       return PLUS_CHAR;
      default: return SLASH_CHAR;
    endcase
  endfunction

  function automatic char_t junk_char();
    char_t c;
    c = char_t'($urandom_range(0, 255));
    if (c == HASH_CHAR) c = "*";
    return c;
  endfunction

  // Mostly pairs and well-formed runs; lone characters and raw bytes break the pairing.
  task automatic send_string();
    char_t seq[$];
    int n_tok;
    int pick;
    int n_dig;
    n_tok = $urandom_range(1, 10);
    for (int t = 0; t < n_tok; t++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        seq.push_back(b64_char());
        seq.push_back(b64_char());
      end else if (pick < 80) begin
        seq.push_back(HASH_CHAR);
        n_dig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
        repeat (n_dig) seq.push_back(char_t'(DIGIT_LO + $urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) seq.push_back(junk_char());
        end
        // leave the last run open now and then so the string end closes it
        if (!(t == n_tok - 1 && $urandom_range(0, 4) == 0)) seq.push_back(HASH_CHAR);
      end else if (pick < 92) begin
        seq.push_back(b64_char());
      end else begin
        seq.push_back(char_t'($urandom_range(0, 255)));
      end
    end
    foreach (seq[i]) send_char(seq[i], i == seq.size() - 1, ROW_PREDICT, '0, '0);
  endtask

  initial begin
    repeat_t cap_plan [NumPhases];
    repeat_t cap;
    int budget;
    int start;
    logic held;
    cap_plan = '{16'd65535, 16'd20, 16'd65535, 16'd3, 16'd1000, 16'd0, 16'd7, 16'd65535};
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CAP) begin
        set_capacity(dir_rows[i].cnt);
      end else begin
        send_char(dir_rows[i].chr, dir_rows[i].fin, dir_rows[i].kind, dir_rows[i].smp,
                  dir_rows[i].cnt);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      idle_pct = (p % 4 == 1) ? 69 : (p % 4 == 3) ? 21 : 0;
      stall_pct = (p % 4 == 2) ? 69 : (p % 4 == 3) ? 21 : 0;
      cap = (p == 4) ? repeat_t'($urandom_range(0, 65535)) : cap_plan[p];
      set_capacity(cap);
      budget = (cap == 0) ? 60 : 260;
      start = chars_sent;
      held = 1'b0;
      while (chars_sent - start < budget) begin
        send_string();
        // long receiver hold-off while the sender keeps offering requests
        if (!held && (p == 0 || p == 4) && chars_sent - start > 100) begin
          hold_req++;
          held = 1'b1;
        end
        if ($urandom_range(0, 19) == 0) wait_drained();
      end
    end

    wait_drained();
    $display("Checked %0d results decoded from %0d characters in %0d strings.",
             results_seen, chars_sent, strings_sent);
    $display("Covered %0d capacity writes from 0 to 65535, four idle/stall mixes, hold-offs.",
             cap_writes);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
